FILE: sv/fgks_pkg.sv
// Shared types and constants of the functional graph k-th successor block.
`timescale 1ns / 1ps

package fgks_pkg;

  localparam int NODE_W  = 10;
  localparam int STEP_W  = 30;
  localparam int COUNT_W = 11;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Node count seen after reset.
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  // Register index, taken from paddr[2].
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

endpackage

FILE: sv/functional_graph_kth_successor.sv
// Top level: binary-lifting k-th successor engine with its command sequencer.
`timescale 1ns / 1ps

// Channel    | Handshake                          | Payload
// -----------+------------------------------------+-------------------------------------
// command in | beat taken when start & !busy      | command, node, successor, step_count
// result out | one beat per cycle with done high  | reached_node
// config     | APB write when psel&penable&pwrite | paddr, pwdata (prdata on reads)
//
// S = compare-subtract steps of the index reduction (0 when NODES >= 1024,
// else number of NODES<<k below 1024). Load: S reduction steps, then a table write.
// Query: walks min(LEVELS, 30) levels, with a reduction and a table read per
// set step bit, bounded by the chain of dependent table reads through the
// single read port. Build: (LEVELS-1) * min(node_count, NODES) entries, two
// dependent reads and one write per entry. Command 3 is taken and dropped at once.
// Reset (rst, synchronous) clears the sequencer and sets node_count to 1024;
// the table is not cleared. The result side cannot stall: done is a pulse.

module functional_graph_kth_successor #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        command,
  input  logic [fgks_pkg::NODE_W-1:0]       node,
  input  logic [fgks_pkg::NODE_W-1:0]       successor,
  input  logic [fgks_pkg::STEP_W-1:0]       step_count,
  // result channel
  output logic                              done,
  output logic [fgks_pkg::NODE_W-1:0]       reached_node,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fgks_pkg::ADDR_W-1:0]       paddr,
  input  logic [fgks_pkg::DATA_W-1:0]       pwdata,
  output logic [fgks_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int IW    = $clog2(NODES);
  localparam int CW    = $clog2(NODES + 1);
  localparam int DEPTH = NODES * LEVELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  // step bits above the field width are never looked at
  localparam int JLIM  = (LEVELS < fgks_pkg::STEP_W) ? LEVELS : fgks_pkg::STEP_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LD_RED = 9'b000000010,
    S_Q_NEXT = 9'b000000100,
    S_Q_RED  = 9'b000001000,
    S_Q_RD   = 9'b000010000,
    S_B_RD1  = 9'b000100000,
    S_B_MID  = 9'b001000000,
    S_B_RED  = 9'b010000000,
    S_B_WR   = 9'b100000000
  } state_t;

  state_t state;

  logic [fgks_pkg::COUNT_W-1:0] node_count;
  logic [CW-1:0]                cnt;
  logic [fgks_pkg::NODE_W-1:0]  cur;
  logic [fgks_pkg::NODE_W-1:0]  succ_r;
  logic [fgks_pkg::STEP_W-1:0]  steps_r;
  logic [LVW-1:0]               lvl;
  logic [IW-1:0]                i;

  logic                         accept;
  logic                         cfg_wr;
  logic [CW-1:0]                cnt_eff;

  logic                         red_start;
  logic [fgks_pkg::NODE_W-1:0]  red_value;
  logic                         red_busy;
  logic [IW-1:0]                red_idx;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [fgks_pkg::NODE_W-1:0]  mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [fgks_pkg::NODE_W-1:0]  mem_rdata;

  logic                         q_last;
  logic                         i_last;

  // Flat table address: level-major, NODES entries per level.
  function automatic logic [AW-1:0] slot(input logic [LVW-1:0] level,
                                         input logic [IW-1:0]  index);
    return AW'(AW'(level) * AW'(NODES) + AW'(index));
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= fgks_pkg::NODE_COUNT_RESET;
    end else if (cfg_wr && (paddr[2] == fgks_pkg::REG_NODE_COUNT)) begin
      node_count <= pwdata[fgks_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == fgks_pkg::REG_NODE_COUNT) begin
      prdata = {{(fgks_pkg::DATA_W - fgks_pkg::COUNT_W){1'b0}}, node_count};
    end else begin
      prdata = '0;
    end
  end

  // node count clamped to the table size
  assign cnt_eff = (32'(node_count) > 32'(NODES)) ? CW'(NODES) : CW'(node_count);

  // ---- shared reduction unit ----
  assign red_start = (accept && (command == fgks_pkg::CMD_LOAD))
                   || ((state == S_Q_NEXT) && steps_r[0])
                   || (state == S_B_MID);

  always_comb begin
    if (state == S_IDLE) begin
      red_value = node;
    end else if (state == S_B_MID) begin
      red_value = mem_rdata;
    end else begin
      red_value = cur;
    end
  end

  fgks_reduce #(
    .NODES (NODES),
    .IW    (IW)
  ) u_reduce (
    .clk   (clk),
    .rst   (rst),
    .start (red_start),
    .value (red_value),
    .busy  (red_busy),
    .idx   (red_idx)
  );

  // ---- table ----
  assign mem_raddr = slot(lvl, (state == S_B_RD1) ? i : red_idx);
  assign mem_we    = ((state == S_LD_RED) && !red_busy) || (state == S_B_WR);
  assign mem_waddr = (state == S_B_WR) ? slot(LVW'(lvl + 1'b1), i) : slot('0, red_idx);
  assign mem_wdata = (state == S_B_WR) ? mem_rdata : succ_r;

  fgks_lift_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign q_last = (lvl == LVW'(JLIM - 1));
  assign i_last = ((CW'(i) + 1'b1) == cnt);

  // ---- result strobe: last level of a query walk ----
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_last && (((state == S_Q_NEXT) && !steps_r[0]) || (state == S_Q_RD));
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (command)
              fgks_pkg::CMD_LOAD:  state <= S_LD_RED;
              fgks_pkg::CMD_BUILD: begin
                if ((LEVELS > 1) && (cnt_eff != '0)) begin
                  state <= S_B_RD1;
                end
              end
              fgks_pkg::CMD_QUERY: state <= S_Q_NEXT;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_LD_RED: begin
          if (!red_busy) begin
            state <= S_IDLE;
          end
        end
        S_Q_NEXT: begin
          if (steps_r[0]) begin
            state <= S_Q_RED;
          end else if (q_last) begin
            state <= S_IDLE;
          end
        end
        S_Q_RED: begin
          if (!red_busy) begin
            state <= S_Q_RD;
          end
        end
        S_Q_RD: begin
          if (q_last) begin
            state <= S_IDLE;
          end else begin
            state <= S_Q_NEXT;
          end
        end
        S_B_RD1: state <= S_B_MID;
        S_B_MID: state <= S_B_RED;
        S_B_RED: begin
          if (!red_busy) begin
            state <= S_B_WR;
          end
        end
        S_B_WR: begin
          if (i_last && (lvl == LVW'(LEVELS - 2))) begin
            state <= S_IDLE;
          end else begin
            state <= S_B_RD1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lvl     <= '0;
        i       <= '0;
        cur     <= node;
        succ_r  <= successor;
        steps_r <= step_count;
        cnt     <= cnt_eff;
      end
      S_Q_NEXT: begin
        if (!steps_r[0]) begin
          steps_r <= steps_r >> 1;
          lvl     <= LVW'(lvl + 1'b1);
          if (q_last) begin
            reached_node <= cur;
          end
        end
      end
      S_Q_RD: begin
        cur     <= mem_rdata;
        steps_r <= steps_r >> 1;
        lvl     <= LVW'(lvl + 1'b1);
        if (q_last) begin
          reached_node <= mem_rdata;
        end
      end
      S_B_WR: begin
        if (i_last) begin
          i   <= '0;
          lvl <= LVW'(lvl + 1'b1);
        end else begin
          i <= IW'(i + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/fgks_lift_mem.sv
// Lifting table storage: one write port, one registered read port.
`timescale 1ns / 1ps

module fgks_lift_mem #(
  parameter int DEPTH  = 30720,
  parameter int AW     = 15
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [fgks_pkg::NODE_W-1:0]    wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [fgks_pkg::NODE_W-1:0]    rdata
);

  logic [fgks_pkg::NODE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fgks_reduce.sv
// Iterative node index reduction modulo NODES: one compare-subtract per cycle.
`timescale 1ns / 1ps

module fgks_reduce #(
  parameter int NODES = 1024,
  parameter int IW    = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fgks_pkg::NODE_W-1:0]    value,
  output logic                           busy,
  output logic [IW-1:0]                  idx
);

  // Number of shifted divisors NODES<<k that fit below 2^NODE_W.
  function automatic int mod_steps(int n);
    int    s;
    longint m;
    s = 0;
    for (m = longint'(n); m < (longint'(1) << fgks_pkg::NODE_W); m = m * 2) begin
      s = s + 1;
    end
    return s;
  endfunction

  localparam int STEPS = mod_steps(NODES);
  localparam int KW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int DIV   = (STEPS > 0) ? NODES : 1;
  localparam int K_TOP = (STEPS > 0) ? STEPS - 1 : 0;

  logic [fgks_pkg::NODE_W-1:0] r;
  logic [KW-1:0]               k;
  logic [fgks_pkg::NODE_W:0]   sub;
  logic                        busy_q;

  assign sub  = (fgks_pkg::NODE_W + 1)'(DIV) << k;
  assign busy = (STEPS > 0) && busy_q;
  assign idx  = IW'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
    end else if (start) begin
      busy_q <= (STEPS > 0);
    end else if (busy_q && (k == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r <= value;
      k <= KW'(K_TOP);
    end else if (busy_q) begin
      if ({1'b0, r} >= sub) begin
        r <= r - sub[fgks_pkg::NODE_W-1:0];
      end
      if (k != '0) begin
        k <= k - 1'b1;
      end
    end
  end

endmodule

FILE: sv/fgks_checker.sv
// Port-level checks for the k-th successor block, bound to its top level.
`timescale 1ns / 1ps

module fgks_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    command,
  input logic                          done,
  input logic                          pready
);

  // a result closes a command, so the block is free while it is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // a result only follows a cycle of work
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in flight");

  // an accepted query always makes the block busy in the cycle after
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == fgks_pkg::CMD_QUERY)) |=> busy)
    else $error("query accepted but block not busy");

  // a load never yields a result beat
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == fgks_pkg::CMD_LOAD)) |=> !done)
    else $error("result after a load");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind functional_graph_kth_successor fgks_checker u_fgks_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .command (command),
  .done    (done),
  .pready  (pready)
);
